>>> sv/tfa_pkg.sv
// ----------------------------------------------------------------------------
// tfa_pkg
// Shared types, codes and helpers for the traffic flow aggregator.
// ----------------------------------------------------------------------------
`default_nettype none

package tfa_pkg;

    // Default table sizes
    localparam int DEF_NODE_SLOTS = 256;
    localparam int DEF_MAX_EDGES  = 1024;

    // Command codes
    localparam logic [1:0] CMD_MERGE     = 2'd0;
    localparam logic [1:0] CMD_READ_NODE = 2'd1;
    localparam logic [1:0] CMD_READ_EDGE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NODE_FULL  = 2'd1;
    localparam logic [1:0] ST_EDGE_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX  = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] src_port_in;
        logic [15:0] dst_port_in;
        logic [31:0] byte_size;
        logic [31:0] duration_ms;
        logic [9:0]  query_index;
    } tfa_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  src_node;
        logic [7:0]  dst_node;
        logic [9:0]  edge_slot;
        logic [47:0] sum_bytes;
        logic [47:0] sum_duration_ms;
        logic [31:0] sessions;
        logic [15:0] last_src_port;
        logic [15:0] last_dst_port;
        logic [31:0] node_address;
        logic [47:0] node_out_total;
        logic [47:0] node_in_total;
    } tfa_out_t;

    // One node table entry
    typedef struct packed {
        logic [31:0] addr;
        logic [47:0] tx_total;
        logic [47:0] rx_total;
    } node_word_t;

    // 48-bit accumulate of a 32-bit amount, clamped at all ones
    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/traffic_flow_aggregator_unit.sv
// ----------------------------------------------------------------------------
// traffic_flow_aggregator_unit
// Flow aggregation table: maps addresses to nodes and merges session records
// into per node-pair edges, with node and edge reads by index.
// ----------------------------------------------------------------------------
// One command is handled at a time. Node and edge state lives in two RAMs with
// registered reads; lookups walk the tables in use one entry per cycle. A merge
// walks the node table for its source, then for its destination, then walks the
// edge table, and then updates the edge and both node totals; a read checks its
// index and then reads the entry, skipping the read when the index is out of
// range; command 3 is dropped with no result. The next command is taken in the cycle
// after a result is loaded. The walks over the node and edge RAM read ports set
// the rate. A finished result waits in the output register while the next
// command is taken; a second result stalls until the first is taken.
`default_nettype none

module traffic_flow_aggregator_unit
#(
    parameter int NODE_SLOTS = tfa_pkg::DEF_NODE_SLOTS,
    parameter int MAX_EDGES  = tfa_pkg::DEF_MAX_EDGES
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tfa_pkg::tfa_in_t  s_payload,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tfa_pkg::tfa_out_t      m_payload
);

    import tfa_pkg::*;

    localparam int NW  = $clog2(NODE_SLOTS);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int PW  = 2 * NW;
    localparam int NCW = NW + 1;
    localparam int ECW = EW + 1;

    typedef struct packed {
        logic [PW-1:0] pair;
        logic [47:0]   bytes;
        logic [47:0]   dur;
        logic [31:0]   sess;
        logic [15:0]   sport;
        logic [15:0]   dport;
    } edge_word_t;

    typedef enum logic [3:0] {
        IDLE, Q_ISSUE, Q_DATA, N_SCAN, E_SCAN, E_UPD,
        NS_RD, NS_WR, ND_RD, ND_WR, RESP
    } state_t;

    state_t          state_reg;
    tfa_in_t         in_reg;
    logic [NCW-1:0]  nodes_used_reg;
    logic [ECW-1:0]  edges_used_reg;
    logic [NCW-1:0]  nidx_reg;
    logic [ECW-1:0]  eidx_reg;
    logic [NW-1:0]   npend_idx_reg;
    logic [EW-1:0]   epend_idx_reg;
    logic            pend_reg;
    logic            dst_phase_reg;
    logic [NW-1:0]   src_node_reg;
    logic [NW-1:0]   dst_node_reg;
    logic [EW-1:0]   slot_reg;
    edge_word_t      ecur_reg;
    tfa_out_t        res_reg;
    logic            m_valid_reg;
    tfa_out_t        m_payload_reg;

    // RAM ports
    logic            n_re, n_we, e_re, e_we;
    logic [NW-1:0]   n_raddr, n_waddr;
    logic [EW-1:0]   e_raddr, e_waddr;
    node_word_t      n_rdata, n_wdata;
    edge_word_t      e_rdata, e_wdata;

    // Lookup decisions
    logic [31:0]     target_addr;
    logic            nhit, nissue, nmiss, nfull;
    logic [PW-1:0]   key;
    logic            ehit, eissue, emiss, efull;
    edge_word_t      eupd;

    tfa_ram #(.DEPTH(NODE_SLOTS), .WIDTH($bits(node_word_t))) u_node_ram (
        .aclk(aclk), .re(n_re), .raddr(n_raddr), .rdata(n_rdata),
        .we(n_we), .waddr(n_waddr), .wdata(n_wdata)
    );

    tfa_ram #(.DEPTH(MAX_EDGES), .WIDTH($bits(edge_word_t))) u_edge_ram (
        .aclk(aclk), .re(e_re), .raddr(e_raddr), .rdata(e_rdata),
        .we(e_we), .waddr(e_waddr), .wdata(e_wdata)
    );

    // Result fields of one edge
    function automatic tfa_out_t edge_result(input edge_word_t w, input logic [EW-1:0] k);
        tfa_out_t r;
        r                 = '0;
        r.status          = ST_OK;
        r.src_node        = 8'(w.pair[PW-1:NW]);
        r.dst_node        = 8'(w.pair[NW-1:0]);
        r.edge_slot       = 10'(k);
        r.sum_bytes       = w.bytes;
        r.sum_duration_ms = w.dur;
        r.sessions        = w.sess;
        r.last_src_port   = w.sport;
        r.last_dst_port   = w.dport;
        return r;
    endfunction

    // Lookup compare against the entry read last cycle
    assign target_addr = dst_phase_reg ? in_reg.dst_address : in_reg.src_address;
    assign nhit   = pend_reg && (n_rdata.addr == target_addr);
    assign nissue = !nhit && (nidx_reg < nodes_used_reg);
    assign nmiss  = !nhit && (nidx_reg == nodes_used_reg);
    assign nfull  = (nodes_used_reg == NCW'(NODE_SLOTS));

    assign key    = {src_node_reg, dst_node_reg};
    assign ehit   = pend_reg && (e_rdata.pair == key);
    assign eissue = !ehit && (eidx_reg < edges_used_reg);
    assign emiss  = !ehit && (eidx_reg == edges_used_reg);
    assign efull  = (edges_used_reg == ECW'(MAX_EDGES));

    // Merged edge entry
    always_comb begin
        eupd       = ecur_reg;
        eupd.bytes = sat_add48(ecur_reg.bytes, in_reg.byte_size);
        eupd.dur   = sat_add48(ecur_reg.dur, in_reg.duration_ms);
        eupd.sess  = (&ecur_reg.sess) ? ecur_reg.sess : ecur_reg.sess + 32'd1;
        eupd.sport = in_reg.src_port_in;
        eupd.dport = in_reg.dst_port_in;
    end

    // RAM control
    always_comb begin
        n_re    = 1'b0;
        n_we    = 1'b0;
        n_raddr = '0;
        n_waddr = '0;
        n_wdata = n_rdata;
        e_re    = 1'b0;
        e_we    = 1'b0;
        e_raddr = '0;
        e_waddr = slot_reg;
        e_wdata = eupd;
        unique case (state_reg)
            Q_ISSUE: begin
                n_re    = (in_reg.cmd == CMD_READ_NODE);
                n_raddr = NW'(in_reg.query_index);
                e_re    = (in_reg.cmd == CMD_READ_EDGE);
                e_raddr = EW'(in_reg.query_index);
            end
            N_SCAN: begin
                n_re    = nissue;
                n_raddr = NW'(nidx_reg);
                n_we    = nmiss && !nfull;
                n_waddr = NW'(nodes_used_reg);
                n_wdata = '{addr: target_addr, tx_total: '0, rx_total: '0};
            end
            E_SCAN: begin
                e_re    = eissue;
                e_raddr = EW'(eidx_reg);
            end
            E_UPD: begin
                e_we = 1'b1;
            end
            NS_RD: begin
                n_re    = 1'b1;
                n_raddr = src_node_reg;
            end
            NS_WR: begin
                n_we             = 1'b1;
                n_waddr          = src_node_reg;
                n_wdata.tx_total = sat_add48(n_rdata.tx_total, in_reg.byte_size);
            end
            ND_RD: begin
                n_re    = 1'b1;
                n_raddr = dst_node_reg;
            end
            ND_WR: begin
                n_we             = 1'b1;
                n_waddr          = dst_node_reg;
                n_wdata.rx_total = sat_add48(n_rdata.rx_total, in_reg.byte_size);
            end
            default: begin
            end
        endcase
    end

    // Control sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= IDLE;
            nodes_used_reg <= '0;
            edges_used_reg <= '0;
            pend_reg       <= 1'b0;
            dst_phase_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // RESP reloads the output register itself
            if (m_valid_reg && m_ready && (state_reg != RESP)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        in_reg        <= s_payload;
                        nidx_reg      <= '0;
                        pend_reg      <= 1'b0;
                        dst_phase_reg <= 1'b0;
                        res_reg       <= '0;
                        priority case (s_payload.cmd)
                            CMD_MERGE:     state_reg <= N_SCAN;
                            CMD_READ_NODE: state_reg <= Q_ISSUE;
                            CMD_READ_EDGE: state_reg <= Q_ISSUE;
                            default:       state_reg <= IDLE;
                        endcase
                    end
                end
                Q_ISSUE: begin
                    if (in_reg.cmd == CMD_READ_NODE) begin
                        if (32'(in_reg.query_index) >= 32'(nodes_used_reg)) begin
                            res_reg.status <= ST_BAD_INDEX;
                            state_reg      <= RESP;
                        end else begin
                            state_reg <= Q_DATA;
                        end
                    end else begin
                        if (32'(in_reg.query_index) >= 32'(edges_used_reg)) begin
                            res_reg.status <= ST_BAD_INDEX;
                            state_reg      <= RESP;
                        end else begin
                            state_reg <= Q_DATA;
                        end
                    end
                end
                Q_DATA: begin
                    if (in_reg.cmd == CMD_READ_NODE) begin
                        res_reg.src_node       <= 8'(in_reg.query_index);
                        res_reg.node_address   <= n_rdata.addr;
                        res_reg.node_out_total <= n_rdata.tx_total;
                        res_reg.node_in_total  <= n_rdata.rx_total;
                    end else begin
                        res_reg <= edge_result(e_rdata, EW'(in_reg.query_index));
                    end
                    state_reg <= RESP;
                end
                N_SCAN: begin
                    // a hit or a miss issues no read, so pend_reg clears here
                    pend_reg <= nissue;
                    if (nissue) begin
                        nidx_reg      <= nidx_reg + NCW'(1);
                        npend_idx_reg <= NW'(nidx_reg);
                    end
                    if (nhit || (nmiss && !nfull)) begin
                        // node found or allocated
                        if (!dst_phase_reg) begin
                            src_node_reg  <= nhit ? npend_idx_reg : NW'(nodes_used_reg);
                            dst_phase_reg <= 1'b1;
                            nidx_reg      <= '0;
                        end else begin
                            dst_node_reg <= nhit ? npend_idx_reg : NW'(nodes_used_reg);
                            eidx_reg     <= '0;
                            state_reg    <= E_SCAN;
                        end
                        if (!nhit) begin
                            nodes_used_reg <= nodes_used_reg + NCW'(1);
                        end
                    end else if (nmiss) begin
                        res_reg.status <= ST_NODE_FULL;
                        state_reg      <= RESP;
                    end
                end
                E_SCAN: begin
                    pend_reg <= eissue;
                    if (eissue) begin
                        eidx_reg      <= eidx_reg + ECW'(1);
                        epend_idx_reg <= EW'(eidx_reg);
                    end
                    if (ehit) begin
                        ecur_reg  <= e_rdata;
                        slot_reg  <= epend_idx_reg;
                        state_reg <= E_UPD;
                    end else if (emiss && !efull) begin
                        ecur_reg       <= '{pair: key, default: '0};
                        slot_reg       <= EW'(edges_used_reg);
                        edges_used_reg <= edges_used_reg + ECW'(1);
                        state_reg      <= E_UPD;
                    end else if (emiss) begin
                        res_reg.status <= ST_EDGE_FULL;
                        state_reg      <= RESP;
                    end
                end
                E_UPD: begin
                    res_reg   <= edge_result(eupd, slot_reg);
                    state_reg <= NS_RD;
                end
                NS_RD: state_reg <= NS_WR;
                NS_WR: state_reg <= ND_RD;
                ND_RD: state_reg <= ND_WR;
                ND_WR: state_reg <= RESP;
                RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_payload_reg <= res_reg;
                        state_reg     <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Table counts stay within their tables; the node count grows by at most one per cycle
    a_nodes_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nodes_used_reg <= NCW'(NODE_SLOTS)) else $error("node count beyond table");
    a_edges_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        edges_used_reg <= ECW'(MAX_EDGES)) else $error("edge count beyond table");
    a_nodes_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (nodes_used_reg == $past(nodes_used_reg))
              || (nodes_used_reg == $past(nodes_used_reg) + NCW'(1)))
        else $error("node count jumped");
    a_edge_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (edges_used_reg != $past(edges_used_reg)) |-> (state_reg == E_UPD))
        else $error("edge allocated outside of merge");

endmodule

`default_nettype wire

>>> sv/tfa_ram.sv
// ----------------------------------------------------------------------------
// tfa_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tfa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 128
) (
    input  wire logic                      aclk,
    input  wire logic                      re,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]          rdata,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for traffic_flow_aggregator_unit: drives merge records and node
// and edge reads, predicts each result from a local copy of the flow tables,
// and checks every result transfer field by field in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tfa_pkg::*;

    localparam int NODES = DEF_NODE_SLOTS;
    localparam int EDGES = DEF_MAX_EDGES;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [47:0] ALL48 = {48{1'b1}};
    localparam int CYCLE_LIMIT = 10000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tfa_in_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    tfa_out_t m_payload;

    traffic_flow_aggregator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    always #5 aclk = ~aclk;

    // predicted flow table
    logic [31:0] nd_addr [NODES];
    logic [47:0] nd_out [NODES];
    logic [47:0] nd_in [NODES];
    int          nd_count;
    int          eg_src [EDGES];
    int          eg_dst [EDGES];
    logic [47:0] eg_bytes [EDGES];
    logic [47:0] eg_dur [EDGES];
    logic [31:0] eg_sess [EDGES];
    logic [15:0] eg_sport [EDGES];
    logic [15:0] eg_dport [EDGES];
    int          eg_count;

    tfa_in_t  pending_cmds[$];
    tfa_out_t expected_results[$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  calm = 0;
    bit  hold_sender = 0;

    // input transfer seen at the last rising edge
    logic s_fire = 1'b0;

    // address pool so records hit existing nodes
    logic [31:0] addr_pool[$];

    function automatic logic [47:0] clamp_add(logic [47:0] a, logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[48] ? ALL48 : s[47:0];
    endfunction

    // returns node number, or -1 when the table is full
    function automatic int map_node(logic [31:0] a);
        for (int i = 0; i < nd_count; i++)
            if (nd_addr[i] == a) return i;
        if (nd_count >= NODES) return -1;
        nd_addr[nd_count] = a;
        nd_out[nd_count] = '0;
        nd_in[nd_count] = '0;
        nd_count++;
        return nd_count - 1;
    endfunction

    function automatic tfa_out_t edge_view(int k);
        tfa_out_t r;
        r = '0;
        r.src_node = eg_src[k][7:0];
        r.dst_node = eg_dst[k][7:0];
        r.edge_slot = k[9:0];
        r.sum_bytes = eg_bytes[k];
        r.sum_duration_ms = eg_dur[k];
        r.sessions = eg_sess[k];
        r.last_src_port = eg_sport[k];
        r.last_dst_port = eg_dport[k];
        return r;
    endfunction

    // apply one command to the table, queueing its result if any
    task automatic aggregate(input tfa_in_t c);
        tfa_out_t r;
        int s, d, k;
        r = '0;
        if (c.cmd == CMD_UNUSED) return;
        if (c.cmd == CMD_READ_NODE) begin
            if (c.query_index >= nd_count) r.status = ST_BAD_INDEX;
            else begin
                r.src_node = c.query_index[7:0];
                r.node_address = nd_addr[c.query_index];
                r.node_out_total = nd_out[c.query_index];
                r.node_in_total = nd_in[c.query_index];
            end
        end else if (c.cmd == CMD_READ_EDGE) begin
            if (c.query_index >= eg_count) r.status = ST_BAD_INDEX;
            else r = edge_view(c.query_index);
        end else begin
            s = map_node(c.src_address);
            d = (s < 0) ? -1 : map_node(c.dst_address);
            if (d < 0) r.status = ST_NODE_FULL;
            else begin
                k = -1;
                for (int i = 0; i < eg_count; i++)
                    if (eg_src[i] == s && eg_dst[i] == d) begin
                        k = i;
                        break;
                    end
                if (k < 0 && eg_count >= EDGES) r.status = ST_EDGE_FULL;
                else begin
                    if (k < 0) begin
                        k = eg_count++;
                        eg_src[k] = s;
                        eg_dst[k] = d;
                        eg_bytes[k] = '0;
                        eg_dur[k] = '0;
                        eg_sess[k] = '0;
                    end
                    eg_bytes[k] = clamp_add(eg_bytes[k], c.byte_size);
                    eg_dur[k] = clamp_add(eg_dur[k], c.duration_ms);
                    if (eg_sess[k] != 32'hFFFF_FFFF) eg_sess[k]++;
                    eg_sport[k] = c.src_port_in;
                    eg_dport[k] = c.dst_port_in;
                    nd_out[s] = clamp_add(nd_out[s], c.byte_size);
                    nd_in[d] = clamp_add(nd_in[d], c.byte_size);
                    r = edge_view(k);
                end
            end
        end
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // driver: new transfer presented at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fire) begin
                aggregate(s_payload);
                void'(pending_cmds.pop_front());
            end
            if (!s_valid || s_fire) begin
                if (pending_cmds.size() > 0
                    && !(hold_sender && expected_results.size() > 0)
                    && (calm || $urandom_range(99) >= 14)) begin
                    s_valid <= 1'b1;
                    s_payload <= pending_cmds[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 14);
        end
    end

    // the driver sees acceptance on the next falling edge; mark it here
    always @(posedge aclk) begin
        s_fire <= s_valid && s_ready && aresetn;
    end

    // monitor
    always @(posedge aclk) begin
        tfa_out_t w;
        cycles++;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected result", 64'(m_payload.status), 64'd0);
            end else begin
                w = expected_results.pop_front();
                if (m_payload.status != w.status)
                    report("status", 64'(m_payload.status), 64'(w.status));
                if (m_payload.src_node != w.src_node)
                    report("src_node", 64'(m_payload.src_node), 64'(w.src_node));
                if (m_payload.dst_node != w.dst_node)
                    report("dst_node", 64'(m_payload.dst_node), 64'(w.dst_node));
                if (m_payload.edge_slot != w.edge_slot)
                    report("edge_slot", 64'(m_payload.edge_slot), 64'(w.edge_slot));
                if (m_payload.sum_bytes != w.sum_bytes)
                    report("sum_bytes", 64'(m_payload.sum_bytes), 64'(w.sum_bytes));
                if (m_payload.sum_duration_ms != w.sum_duration_ms)
                    report("sum_duration_ms", 64'(m_payload.sum_duration_ms),
                           64'(w.sum_duration_ms));
                if (m_payload.sessions != w.sessions)
                    report("sessions", 64'(m_payload.sessions), 64'(w.sessions));
                if (m_payload.last_src_port != w.last_src_port)
                    report("last_src_port", 64'(m_payload.last_src_port),
                           64'(w.last_src_port));
                if (m_payload.last_dst_port != w.last_dst_port)
                    report("last_dst_port", 64'(m_payload.last_dst_port),
                           64'(w.last_dst_port));
                if (m_payload.node_address != w.node_address)
                    report("node_address", 64'(m_payload.node_address),
                           64'(w.node_address));
                if (m_payload.node_out_total != w.node_out_total)
                    report("node_out_total", 64'(m_payload.node_out_total),
                           64'(w.node_out_total));
                if (m_payload.node_in_total != w.node_in_total)
                    report("node_in_total", 64'(m_payload.node_in_total),
                           64'(w.node_in_total));
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic tfa_in_t make_merge(logic [31:0] sa, logic [31:0] da,
                                           logic [31:0] nb, logic [31:0] du);
        tfa_in_t c;
        c = '0;
        c.cmd = CMD_MERGE;
        c.src_address = sa;
        c.dst_address = da;
        c.src_port_in = 16'($urandom);
        c.dst_port_in = 16'($urandom);
        c.byte_size = nb;
        c.duration_ms = du;
        c.query_index = 10'($urandom);
        return c;
    endfunction

    // unused fields carry noise
    function automatic tfa_in_t make_read(logic [1:0] op, int idx);
        tfa_in_t c;
        c = '0;
        c.src_address = $urandom;
        c.dst_address = $urandom;
        c.src_port_in = 16'($urandom);
        c.dst_port_in = 16'($urandom);
        c.byte_size = $urandom;
        c.duration_ms = $urandom;
        c.cmd = op;
        c.query_index = idx[9:0];
        return c;
    endfunction

    function automatic logic [31:0] pick_addr();
        if (addr_pool.size() == 0 || $urandom_range(9) < 2) begin
            addr_pool.insert(addr_pool.size(), $urandom);
            return addr_pool[$];
        end
        return addr_pool[$urandom_range(addr_pool.size() - 1)];
    endfunction

    task automatic enqueue(input tfa_in_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge aclk);
    endtask

    task automatic random_items(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 60)
                enqueue(make_merge(pick_addr(), pick_addr(),
                    ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom,
                    ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom));
            else if (r < 75)
                enqueue(make_read(CMD_READ_NODE,
                    ($urandom_range(4) == 0) ? $urandom_range(1023)
                                             : $urandom_range(nd_count + 2)));
            else if (r < 95)
                enqueue(make_read(CMD_READ_EDGE,
                    ($urandom_range(4) == 0) ? $urandom_range(1023)
                                             : $urandom_range(eg_count + 2)));
            else
                enqueue(make_read(CMD_UNUSED, $urandom_range(1023)));
        end
    endtask

    initial begin
        logic [31:0] base;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reads of an empty table, extremes, self-edge
        enqueue(make_read(CMD_READ_NODE, 0));
        enqueue(make_read(CMD_READ_EDGE, 1023));
        enqueue(make_read(CMD_UNUSED, 0));
        enqueue(make_merge(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        enqueue(make_merge(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        enqueue(make_merge(32'hA5A5_5A5A, 32'hA5A5_5A5A, 32'd0, 32'd0));
        enqueue(make_read(CMD_READ_NODE, 1));
        enqueue(make_read(CMD_READ_NODE, 2));
        enqueue(make_read(CMD_READ_NODE, 3));
        enqueue(make_read(CMD_READ_EDGE, 1));
        enqueue(make_read(CMD_READ_EDGE, 2));
        drain();

        // sender holds off after each transfer until its result is back
        random_items(60);
        hold_sender = 1;
        drain();
        hold_sender = 0;

        calm = 1;
        random_items(40);
        drain();
        calm = 0;
        random_items(50);
        drain();

        // node table full: distinct self-edge records, then overflow
        base = $urandom;
        for (int i = 0; nd_count + i < NODES + 3; i++)
            enqueue(make_merge(base + i, base + i, $urandom, $urandom));
        enqueue(make_merge(addr_pool[0], base ^ 32'h8000_0001, 32'd1, 32'd1));
        enqueue(make_read(CMD_READ_NODE, NODES - 1));
        drain();

        // edge table full: fill pairs among existing nodes
        for (int s = 0; s < NODES && eg_count < EDGES; s++)
            for (int d = 0; d < 8; d++) begin
                enqueue(make_merge(nd_addr[s], nd_addr[(s + d + 1) % NODES],
                                   $urandom, $urandom));
                if (pending_cmds.size() >= 16) drain();
                if (eg_count >= EDGES) break;
            end
        drain();
        // new pairs on a full edge table
        enqueue(make_merge(nd_addr[NODES - 1], nd_addr[NODES - 20], $urandom, $urandom));
        enqueue(make_merge(nd_addr[NODES - 1], nd_addr[NODES - 30], $urandom, $urandom));
        enqueue(make_read(CMD_READ_EDGE, EDGES - 1));
        random_items(30);
        drain();

        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
